FILE: sv/mmcf_pkg.sv
package mmcf_pkg;

	localparam logic [2:0] FUNC_CPU_RD = 3'd0;
	localparam logic [2:0] FUNC_CPU_WR = 3'd1;
	localparam logic [2:0] FUNC_PUSH   = 3'd2;
	localparam logic [2:0] FUNC_TAKE   = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;

	localparam logic [1:0] CFG_ENABLE      = 2'd0;
	localparam logic [1:0] CFG_OUT_ADDR    = 2'd1;
	localparam logic [1:0] CFG_IN_ADDR     = 2'd2;
	localparam logic [1:0] CFG_STATUS_ADDR = 2'd3;

	localparam logic [15:0] RST_OUT_ADDR    = 16'hF000;
	localparam logic [15:0] RST_IN_ADDR     = 16'hF001;
	localparam logic [15:0] RST_STATUS_ADDR = 16'hF002;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_OUT_WR,
		OP_IN_RD,
		OP_IN_POP,
		OP_STAT_RD,
		OP_CLAIM_ONLY,
		OP_PUSH,
		OP_TAKE,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

FILE: sv/memory_mapped_console_fifos.sv
// channel   handshake                   payload
// request   req_valid / req_stall       func, addr, data
// response  rsp_valid / rsp_stall       claimed, read_data, push_accepted, take_valid,
//                                       take_byte, in_pending, out_pending, write_total
// config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// The back end takes each item through S_IDLE, which updates the FIFO pointers and
// issues the registered store read, then S_READ, which loads the response register,
// before it takes the next. Requests are decoded and held in a two-entry queue,
// so the front keeps accepting while the response waits, until the queue is full.
// Reset clears pointers, total, queue and config registers; store contents stay.
module memory_mapped_console_fifos #(
	parameter int OUT_DEPTH = 1024,
	parameter int IN_DEPTH  = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [2:0]                  func,
	input  logic [15:0]                 addr,
	input  logic [7:0]                  data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        claimed,
	output logic [7:0]                  read_data,
	output logic                        push_accepted,
	output logic                        take_valid,
	output logic [7:0]                  take_byte,
	output logic [$clog2(IN_DEPTH):0]   in_pending,
	output logic [$clog2(OUT_DEPTH):0]  out_pending,
	output logic [31:0]                 write_total,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [15:0]                 cfg_data
);

	mmcf_pkg::cmd_t front_cmd;
	mmcf_pkg::cmd_t head_cmd;
	logic           q_push;
	logic           q_ready;
	logic           q_valid;
	logic           q_pop;

	mmcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.addr      (addr),
		.data      (data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_cmd     (front_cmd)
	);

	mmcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (front_cmd),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_cmd    (head_cmd)
	);

	mmcf_back #(
		.OUT_DEPTH (OUT_DEPTH),
		.IN_DEPTH  (IN_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_cmd         (head_cmd),
		.q_pop         (q_pop),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.claimed       (claimed),
		.read_data     (read_data),
		.push_accepted (push_accepted),
		.take_valid    (take_valid),
		.take_byte     (take_byte),
		.in_pending    (in_pending),
		.out_pending   (out_pending),
		.write_total   (write_total)
	);

endmodule

FILE: sv/mmcf_front.sv
module mmcf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         func,
	input  logic [15:0]        addr,
	input  logic [7:0]         data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               q_ready,
	output logic               q_push,
	output mmcf_pkg::cmd_t     q_cmd
);

	logic        enable_q;
	logic [15:0] out_addr_q;
	logic [15:0] in_addr_q;
	logic [15:0] status_addr_q;
	logic        is_wr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			out_addr_q    <= mmcf_pkg::RST_OUT_ADDR;
			in_addr_q     <= mmcf_pkg::RST_IN_ADDR;
			status_addr_q <= mmcf_pkg::RST_STATUS_ADDR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mmcf_pkg::CFG_ENABLE:      enable_q      <= cfg_data[0];
				mmcf_pkg::CFG_OUT_ADDR:    out_addr_q    <= cfg_data;
				mmcf_pkg::CFG_IN_ADDR:     in_addr_q     <= cfg_data;
				mmcf_pkg::CFG_STATUS_ADDR: status_addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode the bus address once, here; the back end only sees the operation and data byte
	always_comb begin
		is_wr = (func == mmcf_pkg::FUNC_CPU_WR);
		q_cmd.data = data;
		q_cmd.op = mmcf_pkg::OP_NONE;
		case (func)
			mmcf_pkg::FUNC_CPU_RD, mmcf_pkg::FUNC_CPU_WR: begin
				if (enable_q) begin
					if (addr == out_addr_q) begin
						q_cmd.op = is_wr ? mmcf_pkg::OP_OUT_WR : mmcf_pkg::OP_NONE;
					end else if (addr == in_addr_q) begin
						q_cmd.op = is_wr ? mmcf_pkg::OP_IN_POP : mmcf_pkg::OP_IN_RD;
					end else if (addr == status_addr_q) begin
						q_cmd.op = is_wr ? mmcf_pkg::OP_CLAIM_ONLY : mmcf_pkg::OP_STAT_RD;
					end
				end
			end
			mmcf_pkg::FUNC_PUSH:  q_cmd.op = mmcf_pkg::OP_PUSH;
			mmcf_pkg::FUNC_TAKE:  q_cmd.op = mmcf_pkg::OP_TAKE;
			mmcf_pkg::FUNC_CLEAR: q_cmd.op = mmcf_pkg::OP_CLEAR;
			default:              q_cmd.op = mmcf_pkg::OP_NONE;
		endcase
	end

	assign q_push    = req_valid && q_ready;
	assign req_stall = !q_ready;

endmodule

FILE: sv/mmcf_queue.sv
module mmcf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mmcf_pkg::cmd_t push_cmd,
	output logic           push_ready,
	input  logic           pop,
	output logic           pop_valid,
	output mmcf_pkg::cmd_t pop_cmd
);

	mmcf_pkg::cmd_t slot_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/mmcf_back.sv
module mmcf_back #(
	parameter int OUT_DEPTH = 1024,
	parameter int IN_DEPTH  = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  mmcf_pkg::cmd_t              q_cmd,
	output logic                        q_pop,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic                        claimed,
	output logic [7:0]                  read_data,
	output logic                        push_accepted,
	output logic                        take_valid,
	output logic [7:0]                  take_byte,
	output logic [$clog2(IN_DEPTH):0]   in_pending,
	output logic [$clog2(OUT_DEPTH):0]  out_pending,
	output logic [31:0]                 write_total
);

	localparam int OAW = $clog2(OUT_DEPTH);
	localparam int OPW = OAW + 1;
	localparam int IAW = $clog2(IN_DEPTH);
	localparam int IPW = IAW + 1;

	localparam logic [OPW:0]   O_SPAN = (OPW + 1)'(2 * OUT_DEPTH);
	localparam logic [OPW-1:0] O_LAST = OPW'(2 * OUT_DEPTH - 1);
	localparam logic [OPW-1:0] O_FULL = OPW'(OUT_DEPTH);
	localparam logic [IPW:0]   I_SPAN = (IPW + 1)'(2 * IN_DEPTH);
	localparam logic [IPW-1:0] I_LAST = IPW'(2 * IN_DEPTH - 1);
	localparam logic [IPW-1:0] I_FULL = IPW'(IN_DEPTH);

	typedef enum logic {S_IDLE, S_READ} state_t;

	state_t state_q;

	logic [7:0] out_mem [OUT_DEPTH];
	logic [7:0] in_mem  [IN_DEPTH];
	logic [7:0] out_rdata_q;
	logic [7:0] in_rdata_q;

	logic [OPW-1:0] out_wr_q, out_rd_q, out_wr_d, out_rd_d;
	logic [IPW-1:0] in_wr_q, in_rd_q, in_wr_d, in_rd_d;
	logic [31:0]    total_q, total_d;

	logic [OPW-1:0] out_lvl;
	logic [IPW-1:0] in_lvl;
	logic [OAW-1:0] out_wr_slot, out_rd_slot;
	logic [IAW-1:0] in_wr_slot, in_rd_slot;
	logic           out_full, out_empty, in_full, in_empty;
	logic           out_we, in_we;

	logic       exec;
	logic       claimed_d, rsel_d, acc_d, tvalid_d;
	logic [1:0] stat_d;
	logic       claimed_s1, rsel_s1, acc_s1, tvalid_s1;
	logic [1:0] stat_s1;

	always_comb begin
		out_lvl = (out_wr_q >= out_rd_q) ? OPW'(out_wr_q - out_rd_q)
			: OPW'({1'b0, out_wr_q} + O_SPAN - {1'b0, out_rd_q});
		in_lvl  = (in_wr_q >= in_rd_q) ? IPW'(in_wr_q - in_rd_q)
			: IPW'({1'b0, in_wr_q} + I_SPAN - {1'b0, in_rd_q});
		out_wr_slot = (out_wr_q >= O_FULL) ? OAW'(out_wr_q - O_FULL) : out_wr_q[OAW-1:0];
		out_rd_slot = (out_rd_q >= O_FULL) ? OAW'(out_rd_q - O_FULL) : out_rd_q[OAW-1:0];
		in_wr_slot  = (in_wr_q >= I_FULL) ? IAW'(in_wr_q - I_FULL) : in_wr_q[IAW-1:0];
		in_rd_slot  = (in_rd_q >= I_FULL) ? IAW'(in_rd_q - I_FULL) : in_rd_q[IAW-1:0];
		out_full  = (out_lvl == O_FULL);
		out_empty = (out_lvl == '0);
		in_full   = (in_lvl == I_FULL);
		in_empty  = (in_lvl == '0);
	end

	assign exec  = (state_q == S_IDLE) && q_valid && (!rsp_valid || !rsp_stall);
	assign q_pop = exec;

	always_comb begin
		out_wr_d  = out_wr_q;
		out_rd_d  = out_rd_q;
		in_wr_d   = in_wr_q;
		in_rd_d   = in_rd_q;
		total_d   = total_q;
		out_we    = 1'b0;
		in_we     = 1'b0;
		claimed_d = 1'b0;
		rsel_d    = 1'b0;
		acc_d     = 1'b0;
		tvalid_d  = 1'b0;
		stat_d    = 2'b00;
		case (q_cmd.op)
			mmcf_pkg::OP_OUT_WR: begin
				claimed_d = 1'b1;
				total_d   = total_q + 32'd1;
				if (!out_full) begin
					out_we   = 1'b1;
					out_wr_d = (out_wr_q == O_LAST) ? '0 : out_wr_q + 1'b1;
				end
			end
			mmcf_pkg::OP_IN_RD: begin
				claimed_d = 1'b1;
				rsel_d    = !in_empty;
			end
			mmcf_pkg::OP_IN_POP: begin
				claimed_d = 1'b1;
				if (!in_empty) begin
					in_rd_d = (in_rd_q == I_LAST) ? '0 : in_rd_q + 1'b1;
				end
			end
			mmcf_pkg::OP_STAT_RD: begin
				claimed_d = 1'b1;
				stat_d    = {!out_full, !in_empty};
			end
			mmcf_pkg::OP_CLAIM_ONLY: begin
				claimed_d = 1'b1;
			end
			mmcf_pkg::OP_PUSH: begin
				if (!in_full) begin
					in_we   = 1'b1;
					acc_d   = 1'b1;
					in_wr_d = (in_wr_q == I_LAST) ? '0 : in_wr_q + 1'b1;
				end
			end
			mmcf_pkg::OP_TAKE: begin
				if (!out_empty) begin
					tvalid_d = 1'b1;
					out_rd_d = (out_rd_q == O_LAST) ? '0 : out_rd_q + 1'b1;
				end
			end
			mmcf_pkg::OP_CLEAR: begin
				out_wr_d = '0;
				out_rd_d = '0;
				in_wr_d  = '0;
				in_rd_d  = '0;
				total_d  = '0;
			end
			default: ;
		endcase
	end

	// front bytes are read every cycle; the value taken in the exec cycle is used next cycle
	always_ff @(posedge clk) begin
		out_rdata_q <= out_mem[out_rd_slot];
		in_rdata_q  <= in_mem[in_rd_slot];
		if (exec && out_we) begin
			out_mem[out_wr_slot] <= q_cmd.data;
		end
		if (exec && in_we) begin
			in_mem[in_wr_slot] <= q_cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q <= '0;
			out_rd_q <= '0;
			in_wr_q  <= '0;
			in_rd_q  <= '0;
			total_q  <= '0;
		end else if (exec) begin
			out_wr_q <= out_wr_d;
			out_rd_q <= out_rd_d;
			in_wr_q  <= in_wr_d;
			in_rd_q  <= in_rd_d;
			total_q  <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rsp_valid     <= 1'b0;
			claimed_s1    <= 1'b0;
			rsel_s1       <= 1'b0;
			acc_s1        <= 1'b0;
			tvalid_s1     <= 1'b0;
			stat_s1       <= 2'b00;
			claimed       <= 1'b0;
			read_data     <= '0;
			push_accepted <= 1'b0;
			take_valid    <= 1'b0;
			take_byte     <= '0;
			in_pending    <= '0;
			out_pending   <= '0;
			write_total   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rsp_valid && !rsp_stall) begin
						rsp_valid <= 1'b0;
					end
					if (exec) begin
						claimed_s1 <= claimed_d;
						rsel_s1    <= rsel_d;
						acc_s1     <= acc_d;
						tvalid_s1  <= tvalid_d;
						stat_s1    <= stat_d;
						state_q    <= S_READ;
					end
				end
				S_READ: begin
					rsp_valid     <= 1'b1;
					claimed       <= claimed_s1;
					read_data     <= rsel_s1 ? in_rdata_q : {6'b0, stat_s1};
					push_accepted <= acc_s1;
					take_valid    <= tvalid_s1;
					take_byte     <= tvalid_s1 ? out_rdata_q : 8'd0;
					in_pending    <= in_lvl;
					out_pending   <= out_lvl;
					write_total   <= total_q;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/mmcf_checker.sv
module mmcf_checker #(
	parameter int OUT_DEPTH = 1024,
	parameter int IN_DEPTH  = 256
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input logic                        claimed,
	input logic [7:0]                  read_data,
	input logic                        push_accepted,
	input logic                        take_valid,
	input logic [7:0]                  take_byte,
	input logic [$clog2(IN_DEPTH):0]   in_pending,
	input logic [$clog2(OUT_DEPTH):0]  out_pending,
	input logic [31:0]                 write_total
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(take_byte)
			&& $stable(in_pending) && $stable(out_pending) && $stable(write_total))
		else $error("response changed while stalled");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(push_accepted && take_valid)
			&& !(claimed && (push_accepted || take_valid)))
		else $error("response mixes bus, push and take results");

	a_take_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !take_valid |-> take_byte == 8'd0)
		else $error("take byte without a take");

	a_read_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_data != 8'd0 |-> claimed)
		else $error("read data on an unclaimed access");

	a_levels: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> in_pending <= IN_DEPTH && out_pending <= OUT_DEPTH)
		else $error("fill level beyond FIFO depth");

endmodule

bind memory_mapped_console_fifos mmcf_checker #(
	.OUT_DEPTH (OUT_DEPTH),
	.IN_DEPTH  (IN_DEPTH)
) u_mmcf_checker (.*);
